// ===== sv/mpd_pkg.sv =====
`default_nettype none
package mpd_pkg;

  localparam int unsigned BodyLenW   = 28;
  localparam int unsigned FieldLenW  = 16;
  localparam int unsigned CfgDataW   = 28;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned LenCountW  = 3;
  localparam int unsigned MaxLenBytes = 4;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [BodyLenW-1:0]  MaxBodyLenReset    = 28'd512;
  localparam logic [FieldLenW-1:0] MaxTopicLenReset   = 16'd120;
  localparam logic [FieldLenW-1:0] MaxPayloadLenReset = 16'd255;

  localparam logic [3:0] TypePublish  = 4'd3;
  localparam logic [3:0] TypePingresp = 4'd13;

  typedef enum logic [CfgIndexW-1:0] {
    RegMaxBodyLen    = 2'd0,
    RegMaxTopicLen   = 2'd1,
    RegMaxPayloadLen = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhLen  = 2'd1,
    PhBody = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DropNone     = 2'd0,
    DropOversize = 2'd1,
    DropReject   = 2'd2
  } drop_t;

  typedef enum logic [2:0] {
    KindTopic     = 3'd0,
    KindPayload   = 3'd1,
    KindPubEnd    = 3'd2,
    KindPing      = 3'd3,
    KindIgnored   = 3'd4,
    KindOversize  = 3'd5,
    KindRejected  = 3'd6,
    KindMalformed = 3'd7
  } out_kind_t;

  // all results caused by one input byte: an optional data beat then an optional end beat
  typedef struct packed {
    logic                 has_data;
    out_kind_t            data_kind;
    logic [7:0]           data_byte;
    logic                 has_end;
    out_kind_t            end_kind;
    logic [3:0]           ptype;
    logic [FieldLenW-1:0] topic_len;
    logic [FieldLenW-1:0] payload_len;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/mpd_front.sv =====
`default_nettype none
module mpd_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic                               kind,
  input  wire logic [7:0]                         rx_byte,
  input  wire logic [mpd_pkg::BodyLenW-1:0]       max_body_len,
  input  wire logic [mpd_pkg::FieldLenW-1:0]      max_topic_len,
  input  wire logic [mpd_pkg::FieldLenW-1:0]      max_payload_len,
  output logic                                    entry_valid,
  output mpd_pkg::entry_t                         entry
);

  mpd_pkg::phase_t                   phase, phase_next;
  logic [3:0]                        header_type, header_type_next;
  logic [1:0]                        header_qos, header_qos_next;
  logic [mpd_pkg::BodyLenW-1:0]      remaining_len, remaining_len_next;
  logic [mpd_pkg::LenCountW-1:0]     len_count, len_count_next;
  logic [mpd_pkg::BodyLenW-1:0]      body_index, body_index_next;
  logic [mpd_pkg::FieldLenW-1:0]     topic_len, topic_len_next;
  logic [mpd_pkg::FieldLenW-1:0]     payload_count, payload_count_next;
  mpd_pkg::drop_t                    drop_mode, drop_mode_next;

  logic [mpd_pkg::BodyLenW-1:0]      len_part;
  logic [mpd_pkg::BodyLenW-1:0]      len_acc;
  logic [mpd_pkg::LenCountW-1:0]     count_inc;
  logic [mpd_pkg::BodyLenW-1:0]      idx_inc;
  logic [mpd_pkg::FieldLenW-1:0]     tl_v;
  logic [mpd_pkg::FieldLenW-1:0]     pc_v;
  mpd_pkg::drop_t                    drop_v;
  logic [mpd_pkg::FieldLenW:0]       topic_end;
  logic [mpd_pkg::FieldLenW+1:0]     payload_start;
  logic                              is_publish;

  function automatic mpd_pkg::out_kind_t end_kind_f(mpd_pkg::drop_t d, logic [3:0] t);
    mpd_pkg::out_kind_t k;
    priority if (d == mpd_pkg::DropOversize) k = mpd_pkg::KindOversize;
    else if (d == mpd_pkg::DropReject)       k = mpd_pkg::KindRejected;
    else if (t == mpd_pkg::TypePublish)      k = mpd_pkg::KindPubEnd;
    else if (t == mpd_pkg::TypePingresp)     k = mpd_pkg::KindPing;
    else                                     k = mpd_pkg::KindIgnored;
    return k;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mpd_pkg::PhIdle;
      header_type   <= '0;
      header_qos    <= '0;
      remaining_len <= '0;
      len_count     <= '0;
      body_index    <= '0;
      topic_len     <= '0;
      payload_count <= '0;
      drop_mode     <= mpd_pkg::DropNone;
    end else if (accept) begin
      phase         <= phase_next;
      header_type   <= header_type_next;
      header_qos    <= header_qos_next;
      remaining_len <= remaining_len_next;
      len_count     <= len_count_next;
      body_index    <= body_index_next;
      topic_len     <= topic_len_next;
      payload_count <= payload_count_next;
      drop_mode     <= drop_mode_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    header_type_next   = header_type;
    header_qos_next    = header_qos;
    remaining_len_next = remaining_len;
    len_count_next     = len_count;
    body_index_next    = body_index;
    topic_len_next     = topic_len;
    payload_count_next = payload_count;
    drop_mode_next     = drop_mode;

    entry             = '0;
    entry.data_kind   = mpd_pkg::KindTopic;
    entry.end_kind    = mpd_pkg::KindIgnored;
    entry.ptype       = header_type;
    entry.data_byte   = rx_byte;

    len_part  = {{(mpd_pkg::BodyLenW-7){1'b0}}, rx_byte[6:0]};
    unique case (len_count[1:0])
      2'd0:    len_acc = remaining_len | len_part;
      2'd1:    len_acc = remaining_len | (len_part << 7);
      2'd2:    len_acc = remaining_len | (len_part << 14);
      default: len_acc = remaining_len | (len_part << 21);
    endcase
    count_inc = len_count + 1'b1;
    idx_inc   = body_index + 1'b1;
    tl_v      = topic_len;
    pc_v      = payload_count;
    drop_v    = drop_mode;
    is_publish = (header_type == mpd_pkg::TypePublish);
    topic_end  = {1'b0, topic_len} + 17'd2;
    payload_start = {1'b0, topic_end} + ((header_qos != 2'd0) ? 18'd2 : 18'd0);

    if (kind) begin
      phase_next         = mpd_pkg::PhIdle;
      header_type_next   = '0;
      header_qos_next    = '0;
      remaining_len_next = '0;
      len_count_next     = '0;
      body_index_next    = '0;
      topic_len_next     = '0;
      payload_count_next = '0;
      drop_mode_next     = mpd_pkg::DropNone;
    end else begin
      unique case (phase)
        mpd_pkg::PhIdle: begin
          phase_next         = mpd_pkg::PhLen;
          header_type_next   = rx_byte[7:4];
          header_qos_next    = rx_byte[2:1];
          remaining_len_next = '0;
          len_count_next     = '0;
          body_index_next    = '0;
          topic_len_next     = '0;
          payload_count_next = '0;
          drop_mode_next     = mpd_pkg::DropNone;
        end
        mpd_pkg::PhLen: begin
          remaining_len_next = len_acc;
          len_count_next     = count_inc;
          if (rx_byte[7]) begin
            if (count_inc >= mpd_pkg::LenCountW'(mpd_pkg::MaxLenBytes)) begin
              entry.has_end = 1'b1;
              entry.end_kind = mpd_pkg::KindMalformed;
              phase_next         = mpd_pkg::PhIdle;
              header_type_next   = '0;
              header_qos_next    = '0;
              remaining_len_next = '0;
              len_count_next     = '0;
              body_index_next    = '0;
              topic_len_next     = '0;
              payload_count_next = '0;
              drop_mode_next     = mpd_pkg::DropNone;
            end
          end else begin
            phase_next      = mpd_pkg::PhBody;
            body_index_next = '0;
            priority if (len_acc > max_body_len) drop_v = mpd_pkg::DropOversize;
            else if (is_publish && len_acc < 28'd2) drop_v = mpd_pkg::DropReject;
            else drop_v = mpd_pkg::DropNone;
            drop_mode_next = drop_v;
            if (len_acc == '0) begin
              entry.has_end  = 1'b1;
              entry.end_kind = end_kind_f(drop_v, header_type);
              if (drop_v == mpd_pkg::DropNone && is_publish) begin
                entry.topic_len   = topic_len;
                entry.payload_len = payload_count;
              end
              phase_next         = mpd_pkg::PhIdle;
              header_type_next   = '0;
              header_qos_next    = '0;
              remaining_len_next = '0;
              len_count_next     = '0;
              body_index_next    = '0;
              topic_len_next     = '0;
              payload_count_next = '0;
              drop_mode_next     = mpd_pkg::DropNone;
            end
          end
        end
        mpd_pkg::PhBody: begin
          if (drop_mode == mpd_pkg::DropNone && is_publish) begin
            priority if (body_index == '0) begin
              tl_v = {rx_byte, 8'd0};
            end else if (body_index == 28'd1) begin
              tl_v = {topic_len[15:8], rx_byte};
              if (tl_v > max_topic_len ||
                  remaining_len < mpd_pkg::BodyLenW'({1'b0, tl_v} + 17'd2)) begin
                drop_v = mpd_pkg::DropReject;
              end
            end else if (body_index < mpd_pkg::BodyLenW'(topic_end)) begin
              entry.has_data  = 1'b1;
              entry.data_kind = mpd_pkg::KindTopic;
            end else if (body_index >= mpd_pkg::BodyLenW'(payload_start) &&
                         payload_count < max_payload_len) begin
              entry.has_data  = 1'b1;
              entry.data_kind = mpd_pkg::KindPayload;
              pc_v = payload_count + 1'b1;
            end else begin
              // packet id or truncated payload byte: consumed without output
              entry.has_data = 1'b0;
            end
          end
          topic_len_next     = tl_v;
          payload_count_next = pc_v;
          drop_mode_next     = drop_v;
          body_index_next    = idx_inc;
          if (idx_inc >= remaining_len) begin
            entry.has_end  = 1'b1;
            entry.end_kind = end_kind_f(drop_v, header_type);
            if (drop_v == mpd_pkg::DropNone && is_publish) begin
              entry.topic_len   = tl_v;
              entry.payload_len = pc_v;
            end
            phase_next         = mpd_pkg::PhIdle;
            header_type_next   = '0;
            header_qos_next    = '0;
            remaining_len_next = '0;
            len_count_next     = '0;
            body_index_next    = '0;
            topic_len_next     = '0;
            payload_count_next = '0;
            drop_mode_next     = mpd_pkg::DropNone;
          end
        end
        default: begin
          phase_next = mpd_pkg::PhIdle;
        end
      endcase
    end

    entry_valid = accept && (entry.has_data || entry.has_end);
  end

endmodule
`default_nettype wire

// ===== sv/mpd_fifo.sv =====
`default_nettype none
module mpd_fifo #(
  parameter int unsigned DEPTH = mpd_pkg::QueueDepthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire mpd_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  output mpd_pkg::entry_t      rd_data,
  output logic                 full,
  output logic                 empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mpd_pkg::entry_t  slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/mpd_back.sv =====
`default_nettype none
module mpd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpd_pkg::entry_t               head,
  input  wire logic                          q_empty,
  input  wire logic                          pop,
  output logic                               deq,
  output logic                               empty,
  output logic [2:0]                         out_kind,
  output logic [7:0]                         out_byte,
  output logic                               last,
  output logic [3:0]                         packet_type,
  output logic [mpd_pkg::FieldLenW-1:0]      topic_length,
  output logic [mpd_pkg::FieldLenW-1:0]      payload_length
);

  // set once the data beat of a two-beat entry has gone out
  logic half;
  logic data_beat;
  logic beat_taken;

  assign empty      = q_empty;
  assign beat_taken = pop && !q_empty;
  assign data_beat  = head.has_data && !half;
  assign deq        = beat_taken && !(data_beat && head.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
    end else if (beat_taken) begin
      half <= !deq;
    end
  end

  always_comb begin
    packet_type = head.ptype;
    if (data_beat) begin
      out_kind       = head.data_kind;
      out_byte       = head.data_byte;
      last           = 1'b0;
      topic_length   = '0;
      payload_length = '0;
    end else begin
      out_kind       = head.end_kind;
      out_byte       = '0;
      last           = 1'b1;
      topic_length   = head.topic_len;
      payload_length = head.payload_len;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mqtt_packet_deframer_unit.sv =====
`default_nettype none
// channel   direction  handshake            payload
// input     in         push / full          kind, rx_byte
// result    out        empty / pop          out_kind, out_byte, last, packet_type,
//                                           topic_length, payload_length
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// one byte is parsed per cycle in the front end while full is low; its results enter the
// queue the same edge; the result ports show the queue head and give one beat per pop
// a byte that ends a publish with a data byte gives two beats and holds the queue head two pops
// full rises only when all QUEUE_DEPTH queue entries hold unread results
// rst is synchronous: parser back to idle, queue emptied, registers to their defaults
module mqtt_packet_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = mpd_pkg::QueueDepthDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              kind,
  input  wire logic [7:0]                        rx_byte,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [2:0]                             out_kind,
  output logic [7:0]                             out_byte,
  output logic                                   last,
  output logic [3:0]                             packet_type,
  output logic [mpd_pkg::FieldLenW-1:0]          topic_length,
  output logic [mpd_pkg::FieldLenW-1:0]          payload_length,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mpd_pkg::CfgIndexW-1:0]     cfg_index,
  input  wire logic [mpd_pkg::CfgDataW-1:0]      cfg_data
);

  logic [mpd_pkg::BodyLenW-1:0]  max_body_len;
  logic [mpd_pkg::FieldLenW-1:0] max_topic_len;
  logic [mpd_pkg::FieldLenW-1:0] max_payload_len;

  logic            accept;
  logic            entry_valid;
  mpd_pkg::entry_t entry;
  mpd_pkg::entry_t head;
  logic            q_empty;
  logic            deq;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len    <= mpd_pkg::MaxBodyLenReset;
      max_topic_len   <= mpd_pkg::MaxTopicLenReset;
      max_payload_len <= mpd_pkg::MaxPayloadLenReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mpd_pkg::RegMaxBodyLen:    max_body_len    <= cfg_data[mpd_pkg::BodyLenW-1:0];
        mpd_pkg::RegMaxTopicLen:   max_topic_len   <= cfg_data[mpd_pkg::FieldLenW-1:0];
        mpd_pkg::RegMaxPayloadLen: max_payload_len <= cfg_data[mpd_pkg::FieldLenW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  mpd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .kind            (kind),
    .rx_byte         (rx_byte),
    .max_body_len    (max_body_len),
    .max_topic_len   (max_topic_len),
    .max_payload_len (max_payload_len),
    .entry_valid     (entry_valid),
    .entry           (entry)
  );

  mpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (entry_valid),
    .wr_data (entry),
    .rd_en   (deq),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  mpd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .deq            (deq),
    .empty          (empty),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .last           (last),
    .packet_type    (packet_type),
    .topic_length   (topic_length),
    .payload_length (payload_length)
  );

endmodule
`default_nettype wire
